[rtl/fre_pkg.sv]
`default_nettype none

package fre_pkg;

   localparam int FRAME_BYTES_DEFAULT = 18;
   localparam int MAX_FRAMES_DEFAULT  = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int ADDR_W   = 7;
   localparam int OFFSET_W = 5;

   localparam logic [6:0] LENGTH_MAX = 7'd127;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_TOO_LONG  = 2'd2,
      STATUS_OUTSIDE   = 2'd3
   } status_type;

   typedef struct packed {
      logic              header;
      logic              last;
      logic              bad_index;
      logic [1:0]        seq;
      logic [2:0]        count;
      logic [2:0]        index;
      logic [ADDR_W-1:0] base;
      logic [7:0]        data;
      logic [15:0]       handle;
   } item_type;

endpackage

`default_nettype wire

[rtl/fre_front.sv]
`default_nettype none

module fre_front #(
   parameter int FRAME_BYTES = fre_pkg::FRAME_BYTES_DEFAULT,
   parameter int MAX_FRAMES  = fre_pkg::MAX_FRAMES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_first_byte,
   input  wire logic             req_last_byte,
   input  wire logic [15:0]      req_link_handle,
   output logic                  head_valid,
   output fre_pkg::item_type     head_item,
   input  wire logic             head_pop
);

   fre_pkg::item_type                 queue_ff [fre_pkg::QUEUE_DEPTH];
   logic [fre_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [fre_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [fre_pkg::QCNT_W-1:0]        count_ff, count_in;
   fre_pkg::item_type                 item;
   logic                              push;
   logic                              pop;

   always_comb begin
      item.header    = req_first_byte;
      item.last      = req_last_byte;
      item.seq       = req_data_byte[7:6];
      item.count     = req_data_byte[5:3];
      item.index     = req_data_byte[2:0];
      item.bad_index = (req_data_byte[2:0] == 3'd0) ||
                       (req_data_byte[2:0] > 3'(MAX_FRAMES));
      item.base      = fre_pkg::ADDR_W'(({4'b0, req_data_byte[2:0]} - 7'd1) *
                                        7'(FRAME_BYTES));
      item.data      = req_data_byte;
      item.handle    = req_link_handle;
   end

   assign req_ready  = (count_ff != fre_pkg::QCNT_W'(fre_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fre_pkg::QCNT_W'(fre_pkg::QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Empty queue has unequal pointers.");
`endif

endmodule

`default_nettype wire

[rtl/fre_back.sv]
`default_nettype none

module fre_back #(
   parameter int FRAME_BYTES = fre_pkg::FRAME_BYTES_DEFAULT,
   parameter int MAX_FRAMES  = fre_pkg::MAX_FRAMES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire fre_pkg::item_type head_item,
   output logic                  head_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_write_valid,
   output logic [6:0]            rsp_write_addr,
   output logic [7:0]            rsp_write_data,
   output logic                  rsp_packet_done,
   output logic [6:0]            rsp_packet_length,
   output logic [15:0]           rsp_done_handle,
   output logic [1:0]            rsp_status
);

   logic [1:0]                      seq_ff, seq_in;
   logic [2:0]                      expected_ff, expected_in;
   logic [2:0]                      received_ff, received_in;
   logic [MAX_FRAMES-1:0]           mask_ff, mask_in;
   logic [6:0]                      length_ff, length_in;
   logic [fre_pkg::ADDR_W-1:0]      base_ff, base_in;
   logic [fre_pkg::OFFSET_W-1:0]    offset_ff, offset_in;
   logic                            open_ff, open_in;
   logic                            accepted_ff, accepted_in;

   logic                            out_valid_ff;
   logic                            wvalid_ff, wvalid_in;
   logic [6:0]                      waddr_ff, waddr_in;
   logic [7:0]                      wdata_ff, wdata_in;
   logic                            done_ff, done_in;
   logic [6:0]                      plen_ff, plen_in;
   logic [15:0]                     dhandle_ff, dhandle_in;
   fre_pkg::status_type             status_ff, status_in;

   logic                            new_seq;
   logic                            end_frame;
   logic [MAX_FRAMES-1:0]           frame_bit;

   assign head_pop = head_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      seq_in      = seq_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      mask_in     = mask_ff;
      length_in   = length_ff;
      base_in     = base_ff;
      offset_in   = offset_ff;
      open_in     = open_ff;
      accepted_in = accepted_ff;
      wvalid_in   = 1'b0;
      waddr_in    = '0;
      wdata_in    = '0;
      done_in     = 1'b0;
      plen_in     = '0;
      dhandle_in  = '0;
      status_in   = fre_pkg::STATUS_OK;
      new_seq     = head_item.header &&
                    ((head_item.seq != seq_ff) || (received_ff == 3'd0));
      frame_bit   = MAX_FRAMES'(1) << (head_item.index - 3'd1);
      end_frame   = head_item.last && (head_item.header || open_ff);

      if (head_item.header) begin
         if (new_seq) begin
            seq_in      = head_item.seq;
            expected_in = head_item.count;
            length_in   = '0;
            received_in = '0;
            mask_in     = '0;
         end
         open_in     = 1'b1;
         accepted_in = 1'b0;
         offset_in   = '0;
         base_in     = '0;
         if (head_item.bad_index) begin
            status_in = fre_pkg::STATUS_BAD_INDEX;
         end else if ((mask_in & frame_bit) == '0) begin
            mask_in     = mask_in | frame_bit;
            received_in = received_in + 3'd1;
            base_in     = head_item.base;
            accepted_in = 1'b1;
         end
      end else if (!open_ff) begin
         status_in = fre_pkg::STATUS_OUTSIDE;
      end else if (offset_ff >= fre_pkg::OFFSET_W'(FRAME_BYTES)) begin
         status_in = fre_pkg::STATUS_TOO_LONG;
      end else begin
         if (accepted_ff) begin
            wvalid_in = 1'b1;
            waddr_in  = base_ff + {2'b00, offset_ff};
            wdata_in  = head_item.data;
            if (length_ff != fre_pkg::LENGTH_MAX) begin
               length_in = length_ff + 7'd1;
            end
         end
         offset_in = offset_ff + 1'b1;
      end

      if (end_frame) begin
         open_in     = 1'b0;
         accepted_in = 1'b0;
         if ((received_in != 3'd0) && (received_in == expected_in)) begin
            done_in     = 1'b1;
            plen_in     = length_in;
            dhandle_in  = head_item.handle;
            received_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         expected_ff  <= '0;
         received_ff  <= '0;
         mask_ff      <= '0;
         length_ff    <= '0;
         base_ff      <= '0;
         offset_ff    <= '0;
         open_ff      <= 1'b0;
         accepted_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (head_pop) begin
            seq_ff       <= seq_in;
            expected_ff  <= expected_in;
            received_ff  <= received_in;
            mask_ff      <= mask_in;
            length_ff    <= length_in;
            base_ff      <= base_in;
            offset_ff    <= offset_in;
            open_ff      <= open_in;
            accepted_ff  <= accepted_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         wvalid_ff  <= wvalid_in;
         waddr_ff   <= waddr_in;
         wdata_ff   <= wdata_in;
         done_ff    <= done_in;
         plen_ff    <= plen_in;
         dhandle_ff <= dhandle_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_valid   = wvalid_ff;
   assign rsp_write_addr    = waddr_ff;
   assign rsp_write_data    = wdata_ff;
   assign rsp_packet_done   = done_ff;
   assign rsp_packet_length = plen_ff;
   assign rsp_done_handle   = dhandle_ff;
   assign rsp_status        = status_ff;

`ifndef SYNTHESIS
   a_count_vs_mask: assert property (@(posedge clock) disable iff (reset)
      32'(received_ff) <= $countones(mask_ff))
      else $error("Received count exceeds the frames marked in the bitmap.");

   a_accept_open: assert property (@(posedge clock) disable iff (reset)
      accepted_ff |-> open_ff)
      else $error("Frame accepted while no frame is open.");

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= fre_pkg::OFFSET_W'(FRAME_BYTES))
      else $error("Byte offset ran past the frame size.");

   a_write_accepted: assert property (@(posedge clock) disable iff (reset)
      head_pop && wvalid_in |-> accepted_ff && !head_item.header)
      else $error("Write issued for a frame that was not accepted.");
`endif

endmodule

`default_nettype wire

[rtl/fragment_reassembly_engine_top.sv]
`default_nettype none

// Reassembles link frames that arrive one byte per word into a packet buffer.
// Each accepted input word yields exactly one result word: a buffer write for
// a payload byte of a new frame, a completion report with the total length and
// connection handle when the last frame of a sequence ends, and a status code.
// The block sustains one word per clock while the result side is not stalled; a
// result passes through the queue and the output registers before it is presented,
// and is held until the result side takes it. A two-entry queue separates header
// decoding from the state update, so that the input side keeps accepting up to two
// more words while a finished result waits to be taken.

module fragment_reassembly_engine_top #(
   parameter int FRAME_BYTES = fre_pkg::FRAME_BYTES_DEFAULT,
   parameter int MAX_FRAMES  = fre_pkg::MAX_FRAMES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic [15:0] req_link_handle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_write_valid,
   output logic [6:0]       rsp_write_addr,
   output logic [7:0]       rsp_write_data,
   output logic             rsp_packet_done,
   output logic [6:0]       rsp_packet_length,
   output logic [15:0]      rsp_done_handle,
   output logic [1:0]       rsp_status
);

   logic              head_valid;
   logic              head_pop;
   fre_pkg::item_type head_item;

   fre_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .MAX_FRAMES  (MAX_FRAMES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .req_link_handle (req_link_handle),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop)
   );

   fre_back #(
      .FRAME_BYTES (FRAME_BYTES),
      .MAX_FRAMES  (MAX_FRAMES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_addr    (rsp_write_addr),
      .rsp_write_data    (rsp_write_data),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_packet_length (rsp_packet_length),
      .rsp_done_handle   (rsp_done_handle),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

[tb/tb_fragment_reassembly_engine_top.sv]
module tb_fragment_reassembly_engine_top;

   localparam int FRAME_BYTES = fre_pkg::FRAME_BYTES_DEFAULT;
   localparam int MAX_FRAMES  = fre_pkg::MAX_FRAMES_DEFAULT;
   localparam int WORD_TARGET = 1440;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic                wr_valid;
      logic [6:0]          wr_addr;
      logic [7:0]          wr_data;
      logic                done;
      logic [6:0]          length;
      logic [15:0]         handle;
      fre_pkg::status_type status;
   } report_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [15:0] handle;
      logic [7:0]  reps;
      logic        typed;
      report_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_first_byte;
   logic        req_last_byte;
   logic [15:0] req_link_handle;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_write_valid;
   logic [6:0]  rsp_write_addr;
   logic [7:0]  rsp_write_data;
   logic        rsp_packet_done;
   logic [6:0]  rsp_packet_length;
   logic [15:0] rsp_done_handle;
   logic [1:0]  rsp_status;

   fragment_reassembly_engine_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_first_byte    (req_first_byte),
      .req_last_byte     (req_last_byte),
      .req_link_handle   (req_link_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_addr    (rsp_write_addr),
      .rsp_write_data    (rsp_write_data),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_packet_length (rsp_packet_length),
      .rsp_done_handle   (rsp_done_handle),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   logic [1:0]            cur_seq = '0;
   logic [2:0]            frames_wanted = '0;
   logic [2:0]            frames_seen = '0;
   logic [MAX_FRAMES-1:0] seen_mask = '0;
   logic [6:0]            stored_len = '0;
   logic [6:0]            frame_base = '0;
   logic [4:0]            frame_offset = '0;
   logic                  in_frame = 1'b0;
   logic                  taking = 1'b0;

   report_type   awaited_reports[$];
   stim_row_type directed_rows[$];
   report_type   row_want = '0;
   logic         row_typed = 1'b0;
   report_type   got_report;
   report_type   want_report;
   int           mismatches = 0;
   int           words_sent = 0;
   int           rsp_gap = 0;
   bit           quiet_tx = 1'b0;
   bit           quiet_rx = 1'b0;
   bit           hold_off = 1'b0;

   function automatic report_type reassemble_byte(input logic [7:0] d, input logic f,
                                                  input logic l, input logic [15:0] h);
      report_type r;
      logic [1:0] sq;
      logic [2:0] cn;
      logic [2:0] ix;
      logic       ends;
      r = '0;
      r.status = fre_pkg::STATUS_OK;
      ends = l;
      if (f) begin
         sq = d[7:6];
         cn = d[5:3];
         ix = d[2:0];
         if (sq != cur_seq || frames_seen == 0) begin
            cur_seq = sq;
            frames_wanted = cn;
            stored_len = '0;
            frames_seen = '0;
            seen_mask = '0;
         end
         in_frame = 1'b1;
         taking = 1'b0;
         frame_offset = '0;
         frame_base = '0;
         if (ix == 0 || ix > MAX_FRAMES) begin
            r.status = fre_pkg::STATUS_BAD_INDEX;
         end else if (!seen_mask[ix - 1]) begin
            seen_mask[ix - 1] = 1'b1;
            frames_seen = frames_seen + 3'd1;
            frame_base = 7'((int'(ix) - 1) * FRAME_BYTES);
            taking = 1'b1;
         end
      end else if (!in_frame) begin
         r.status = fre_pkg::STATUS_OUTSIDE;
         ends = 1'b0;
      end else if (frame_offset >= FRAME_BYTES) begin
         r.status = fre_pkg::STATUS_TOO_LONG;
      end else begin
         if (taking) begin
            r.wr_valid = 1'b1;
            r.wr_addr = frame_base + 7'(frame_offset);
            r.wr_data = d;
            if (stored_len < fre_pkg::LENGTH_MAX) stored_len = stored_len + 7'd1;
         end
         frame_offset = frame_offset + 5'd1;
      end
      if (ends && in_frame) begin
         in_frame = 1'b0;
         taking = 1'b0;
         if (frames_seen != 0 && frames_seen == frames_wanted) begin
            r.done = 1'b1;
            r.length = stored_len;
            r.handle = h;
            frames_seen = '0;
         end
      end
      return r;
   endfunction

   function automatic report_type make_report(input logic wv, input logic [6:0] wa,
                                              input logic [7:0] wd, input logic dn,
                                              input logic [6:0] len, input logic [15:0] dh,
                                              input fre_pkg::status_type st);
      report_type r;
      r.wr_valid = wv;
      r.wr_addr = wa;
      r.wr_data = wd;
      r.done = dn;
      r.length = len;
      r.handle = dh;
      r.status = st;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] d, input logic f, input logic l,
                          input logic [15:0] h, input int reps, input logic typed,
                          input report_type want);
      stim_row_type row;
      row.data = d;
      row.first = f;
      row.last = l;
      row.handle = h;
      row.reps = 8'(reps);
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch in %s after %0d words: got %h, want %h",
               what, words_sent, got, want);
      mismatches++;
   endtask

   task automatic send_word(input logic [7:0] d, input logic f, input logic l,
                            input logic [15:0] h, input logic typed, input report_type want);
      int gap;
      gap = quiet_tx ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_first_byte <= f;
      req_last_byte <= l;
      req_link_handle <= h;
      row_typed = typed;
      row_want = want;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
   endtask

   task automatic send_frame(input logic [1:0] sq, input logic [2:0] cn,
                             input logic [2:0] ix, input logic [15:0] h);
      int  len;
      bit  close;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(19, 21) : $urandom_range(0, 18);
      close = ($urandom_range(0, 24) != 0);
      send_word({sq, cn, ix}, 1'b1, close && len == 0, h, 1'b0, '0);
      for (int i = 0; i < len; i++) begin
         send_word(8'($urandom_range(0, 255)), 1'b0, close && i == len - 1, h, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            want_report = reassemble_byte(req_data_byte, req_first_byte, req_last_byte,
                                          req_link_handle);
            if (row_typed) want_report = row_want;
            awaited_reports.push_back(want_report);
         end
         if (rsp_valid && rsp_ready) begin
            got_report = make_report(rsp_write_valid, rsp_write_addr, rsp_write_data,
                                     rsp_packet_done, rsp_packet_length, rsp_done_handle,
                                     fre_pkg::status_type'(rsp_status));
            if (awaited_reports.size() == 0) begin
               report_mismatch("result with nothing awaited", 16'd1, 16'd0);
            end else begin
               want_report = awaited_reports.pop_front();
               if (got_report.wr_valid !== want_report.wr_valid)
                  report_mismatch("write_valid", got_report.wr_valid, want_report.wr_valid);
               if (got_report.wr_addr !== want_report.wr_addr)
                  report_mismatch("write_addr", got_report.wr_addr, want_report.wr_addr);
               if (got_report.wr_data !== want_report.wr_data)
                  report_mismatch("write_data", got_report.wr_data, want_report.wr_data);
               if (got_report.done !== want_report.done)
                  report_mismatch("packet_done", got_report.done, want_report.done);
               if (got_report.length !== want_report.length)
                  report_mismatch("packet_length", got_report.length, want_report.length);
               if (got_report.handle !== want_report.handle)
                  report_mismatch("done_handle", got_report.handle, want_report.handle);
               if (got_report.status !== want_report.status)
                  report_mismatch("status", got_report.status, want_report.status);
            end
            rsp_gap = quiet_rx ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset || hold_off || rsp_gap != 0) begin
            rsp_ready <= 1'b0;
            if (!reset && !hold_off && rsp_gap != 0) rsp_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // The receiver stops for a long stretch so that the block fills and holds off its input.
   initial begin
      wait (words_sent >= 400);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [1:0]  sq;
      logic [2:0]  cn;
      logic [15:0] hdl;
      int          nfr;
      int          k;
      int          tmp;
      int          order[MAX_FRAMES];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_first_byte = 1'b0;
      req_last_byte = 1'b0;
      req_link_handle = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(8'hFF, 1'b0, 1'b1, 16'hFFFF, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000,
                          fre_pkg::STATUS_OUTSIDE));
      add_row(8'h08, 1'b1, 1'b1, 16'h0000, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000,
                          fre_pkg::STATUS_BAD_INDEX));
      add_row(8'hFF, 1'b1, 1'b0, 16'h1234, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000,
                          fre_pkg::STATUS_BAD_INDEX));
      add_row(8'h00, 1'b0, 1'b0, 16'h1234, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h4C, 1'b1, 1'b0, 16'hA5A5, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'hF0, 1'b0, 1'b0, 16'hA5A5, 17, 1'b0, '0);
      add_row(8'h80, 1'b0, 1'b0, 16'hA5A5, 1, 1'b1,
              make_report(1'b1, 7'd71, 8'h80, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h01, 1'b0, 1'b1, 16'hFFFF, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b1, 7'd18, 16'hFFFF,
                          fre_pkg::STATUS_TOO_LONG));
      add_row(8'h91, 1'b1, 1'b0, 16'h0101, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h11, 1'b0, 1'b1, 16'h0101, 1, 1'b1,
              make_report(1'b1, 7'd0, 8'h11, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h91, 1'b1, 1'b0, 16'h0101, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h22, 1'b0, 1'b1, 16'h0101, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h92, 1'b1, 1'b0, 16'h00FF, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h33, 1'b0, 1'b0, 16'h00FF, 1, 1'b1,
              make_report(1'b1, 7'd18, 8'h33, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h92, 1'b1, 1'b1, 16'h00FF, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b1, 7'd2, 16'h00FF, fre_pkg::STATUS_OK));
      add_row(8'h01, 1'b1, 1'b1, 16'h7E7E, 1, 1'b1,
              make_report(1'b0, 7'd0, 8'h00, 1'b0, 7'd0, 16'h0000, fre_pkg::STATUS_OK));
      add_row(8'h02, 1'b1, 1'b1, 16'h7E7E, 1, 1'b0, '0);

      foreach (directed_rows[i]) begin
         for (int r = 0; r < directed_rows[i].reps; r++) begin
            send_word(directed_rows[i].data + 8'(r), directed_rows[i].first,
                      directed_rows[i].last, directed_rows[i].handle,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Mostly whole packets with shuffled frames, plus a little noise.
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 1'b0, '0);
            end
         end else begin
            sq = 2'($urandom_range(0, 3));
            cn = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, MAX_FRAMES))
                                            : 3'($urandom_range(0, 7));
            hdl = 16'($urandom_range(0, 65535));
            nfr = (cn == 0 || cn > MAX_FRAMES) ? $urandom_range(1, MAX_FRAMES) : cn;
            for (int j = 0; j < nfr; j++) order[j] = j + 1;
            for (int j = nfr - 1; j > 0; j--) begin
               k = $urandom_range(0, j);
               tmp = order[j];
               order[j] = order[k];
               order[k] = tmp;
            end
            for (int j = 0; j < nfr; j++) begin
               if ($urandom_range(0, 9) == 0) send_frame(sq, cn, 3'($urandom_range(0, 7)), hdl);
               send_frame(sq, cn, 3'(order[j]), hdl);
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
rtl/fre_pkg.sv
rtl/fre_front.sv
rtl/fre_back.sv
rtl/fragment_reassembly_engine_top.sv
tb/tb_fragment_reassembly_engine_top.sv
